### rtl/mmfn_pkg.sv
// Shared types and constants for the min-max feature normalizer.
// No dependencies; every other file in rtl/ imports this package.
package mmfn_pkg;

    localparam int MMFN_MAX_FEATURES = 1024;
    localparam int MMFN_QW           = 16;
    localparam int MMFN_CNT_W        = 11;
    localparam logic [MMFN_CNT_W-1:0] MMFN_COUNT_RESET = 11'd784;
    localparam logic [16:0] MMFN_ONE = 17'h10000;

    localparam logic MMFN_REQ_OBSERVE   = 1'b0;
    localparam logic MMFN_REQ_NORMALIZE = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [9:0]         feature_index;
        logic               first_sample;
        logic signed [31:0] sample_value;
    } t_mmfn_req;

    typedef struct packed {
        logic [16:0] scaled_value;
        logic [9:0]  result_index;
        logic        flat_range;
    } t_mmfn_res;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_CLASS,
        ST_DIV
    } t_mmfn_state;

    typedef struct packed {
        logic min_we;
        logic max_we;
    } t_store_we;

    typedef struct packed {
        logic        load;
        logic [31:0] num;
        logic [31:0] den;
    } t_div_in;

endpackage

### rtl/mmfn_store.sv
// Per-feature minimum and maximum storage, one read and one write port each.
// Depends on mmfn_pkg for the write-enable struct.
module mmfn_store #(
    parameter int DEPTH = mmfn_pkg::MMFN_MAX_FEATURES,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  i_clk,
    input  logic [AW-1:0]         i_addr,
    input  mmfn_pkg::t_store_we   i_we,
    input  logic signed [31:0]    i_wdata,
    output logic signed [31:0]    o_min,
    output logic signed [31:0]    o_max
);
    import mmfn_pkg::*;

    logic signed [31:0] r_min_mem [DEPTH];
    logic signed [31:0] r_max_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we.min_we) begin
            r_min_mem[i_addr] <= i_wdata;
        end
        o_min <= r_min_mem[i_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we.max_we) begin
            r_max_mem[i_addr] <= i_wdata;
        end
        o_max <= r_max_mem[i_addr];
    end

endmodule

### rtl/mmfn_div.sv
// Restoring radix-2 divider: one quotient bit per cycle, fraction of num/den.
// Expects num < den; depends on mmfn_pkg for the load struct and quotient width.
module mmfn_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mmfn_pkg::t_div_in             i_div,
    output logic                          o_done,
    output logic [mmfn_pkg::MMFN_QW-1:0]  o_quo
);
    import mmfn_pkg::*;

    localparam int CW = $clog2(MMFN_QW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [32:0]   r_rem;
    logic [31:0]   r_den;
    logic [MMFN_QW-1:0] r_quo;

    logic [33:0] trial;
    logic        fits;

    always_comb begin
        trial = {r_rem, 1'b0} - {2'b00, r_den};
        fits  = ~trial[33];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_div.load) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_div.load) begin
            r_rem <= {1'b0, i_div.num};
            r_den <= i_div.den;
            r_cnt <= CW'(MMFN_QW - 1);
        end else if (r_busy) begin
            // keep the partial remainder when the trial subtraction borrows
            r_rem <= fits ? trial[32:0] : {r_rem[31:0], 1'b0};
            r_quo <= {r_quo[MMFN_QW-2:0], fits};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < {1'b0, r_den}))
        else $error("divider remainder reached divisor");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a running division");

endmodule

### rtl/min_max_feature_normalizer_unit.sv
// Min-max feature normalizer: per-feature min/max store plus sequenced scaler.
// Depends on mmfn_pkg, mmfn_store and mmfn_div.
//
// Usage:
//   Request channel: present i_req and raise start; the transaction is taken
//   on a rising edge where start is high and busy is low. busy stays high
//   while the request works through the sequencer.
//   Result channel: o_done pulses for one cycle with o_res; there is no
//   backpressure, so the receiver must take it in that cycle.
//   Config: i_cfg_we writes i_cfg_wdata to feature_count; write only when idle.
// Sequence after the accept edge:
//   Request with index not in use: dropped at once, busy never rises.
//   Observe: min/max read, then compare and write back.
//   Normalize with flat, below-min or above-max outcome: classify, then o_done.
//   Normalize needing a division: the radix-2 divider runs, then o_done
//   follows; the next request can be taken in the cycle o_done is high.
// Reset restores feature_count to 784 and returns the sequencer to idle. The
// feature stores are not cleared: normalize only features already observed,
// and make the first observe of each feature carry first_sample.
module min_max_feature_normalizer_unit #(
    parameter int MAX_FEATURES = mmfn_pkg::MMFN_MAX_FEATURES
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  mmfn_pkg::t_mmfn_req                i_req,
    output logic                               o_done,
    output mmfn_pkg::t_mmfn_res                o_res,
    input  logic                               i_cfg_we,
    input  logic [mmfn_pkg::MMFN_CNT_W-1:0]    i_cfg_wdata
);
    import mmfn_pkg::*;

    localparam int AW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;

    t_mmfn_state r_state, n_state;

    logic [MMFN_CNT_W-1:0] r_count;
    t_mmfn_req             r_req;
    logic signed [32:0]    r_range;
    logic signed [32:0]    r_num;
    logic                  r_done;
    t_mmfn_res             r_res;

    logic                  accept;
    logic                  in_use;
    logic [31:0]           idx_wide;
    logic [AW-1:0]         addr;
    t_store_we             store_we;
    logic signed [31:0]    rd_min;
    logic signed [31:0]    rd_max;
    t_div_in               div_in;
    logic                  div_done;
    logic [MMFN_QW-1:0]    div_quo;
    logic                  fin_now;
    t_mmfn_res             fin_res;
    logic                  is_flat;
    logic                  is_low;
    logic                  is_high;

    assign busy = (r_state != ST_IDLE);

    always_comb begin
        in_use = (32'(i_req.feature_index) < 32'(r_count))
              && (32'(i_req.feature_index) < 32'(MAX_FEATURES));
        accept = start && !busy;
    end

    always_comb begin
        idx_wide = 32'(r_req.feature_index);
        addr     = idx_wide[AW-1:0];
    end

    always_comb begin
        is_flat = r_range[32] || (r_range == '0);
        is_low  = r_num[32] || (r_num == '0);
        is_high = (r_num >= r_range);
    end

    mmfn_store #(
        .DEPTH (MAX_FEATURES),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_addr  (addr),
        .i_we    (store_we),
        .i_wdata (r_req.sample_value),
        .o_min   (rd_min),
        .o_max   (rd_max)
    );

    mmfn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_div   (div_in),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && in_use) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                n_state = (r_req.req_type == MMFN_REQ_NORMALIZE) ? ST_CLASS : ST_IDLE;
            end
            ST_CLASS: begin
                n_state = (is_flat || is_low || is_high) ? ST_IDLE : ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        store_we     = '0;
        div_in.load  = 1'b0;
        div_in.num   = r_num[31:0];
        div_in.den   = r_range[31:0];
        fin_now      = 1'b0;
        fin_res.scaled_value = '0;
        fin_res.result_index = r_req.feature_index;
        fin_res.flat_range   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
            end
            ST_READ: begin
            end
            ST_EVAL: begin
                if (r_req.req_type == MMFN_REQ_OBSERVE) begin
                    store_we.min_we = r_req.first_sample || (r_req.sample_value < rd_min);
                    store_we.max_we = r_req.first_sample || (r_req.sample_value > rd_max);
                end
            end
            ST_CLASS: begin
                if (is_flat) begin
                    fin_now            = 1'b1;
                    fin_res.flat_range = 1'b1;
                end else if (is_low) begin
                    fin_now = 1'b1;
                end else if (is_high) begin
                    fin_now              = 1'b1;
                    fin_res.scaled_value = MMFN_ONE;
                end else begin
                    div_in.load = 1'b1;
                end
            end
            ST_DIV: begin
                fin_now              = div_done;
                fin_res.scaled_value = {1'b0, div_quo};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= MMFN_COUNT_RESET;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= fin_now;
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
        if (r_state == ST_EVAL) begin
            r_range <= {rd_max[31], rd_max} - {rd_min[31], rd_min};
            r_num   <= {r_req.sample_value[31], r_req.sample_value} - {rd_min[31], rd_min};
        end
        if (fin_now) begin
            r_res <= fin_res;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while sequencer still busy");

    a_flat_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.flat_range) |-> (o_res.scaled_value == '0))
        else $error("flat range with nonzero scaled value");

    a_scaled_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_res.scaled_value <= MMFN_ONE))
        else $error("scaled value above one");

    a_no_store_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (store_we.min_we || store_we.max_we) |-> (r_state == ST_EVAL))
        else $error("store written outside evaluation step");

endmodule

### tb/tb_min_max_feature_normalizer_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for min_max_feature_normalizer_unit: drives observe and
// normalize transactions and checks every result against its own min/max scaler.
// Depends on mmfn_pkg and the RTL under rtl/.

module tb_min_max_feature_normalizer_unit;
    import mmfn_pkg::*;

    class minmax_scoreboard;
        logic [MMFN_CNT_W-1:0] feature_count;
        logic signed [31:0]    min_store [MMFN_MAX_FEATURES];
        logic signed [31:0]    max_store [MMFN_MAX_FEATURES];
        bit                    written [MMFN_MAX_FEATURES];
        t_mmfn_res             pending_scales [$];
        int                    mismatches;

        function new();
            feature_count = MMFN_COUNT_RESET;
            mismatches    = 0;
            foreach (written[i]) written[i] = 1'b0;
        endfunction

        function int unsigned in_use();
            return (feature_count > MMFN_MAX_FEATURES) ? MMFN_MAX_FEATURES : feature_count;
        endfunction

        // Update the min/max copy, or predict the scaled value of a normalize.
        function void note_request(t_mmfn_req r);
            int unsigned idx;
            longint      lo, hi, span, num;
            t_mmfn_res   res;
            idx = 32'(r.feature_index);
            if (idx >= in_use()) return;
            if (r.req_type == MMFN_REQ_OBSERVE) begin
                if (r.first_sample) begin
                    min_store[idx] = r.sample_value;
                    max_store[idx] = r.sample_value;
                    written[idx]   = 1'b1;
                end else begin
                    if (r.sample_value < min_store[idx]) min_store[idx] = r.sample_value;
                    if (r.sample_value > max_store[idx]) max_store[idx] = r.sample_value;
                end
                return;
            end
            lo   = longint'(min_store[idx]);
            hi   = longint'(max_store[idx]);
            span = hi - lo;
            num  = longint'(r.sample_value) - lo;
            res.result_index = r.feature_index;
            res.flat_range   = 1'b0;
            res.scaled_value = '0;
            if (span <= 0) begin
                res.flat_range = 1'b1;
            end else if (num >= span) begin
                res.scaled_value = MMFN_ONE;
            end else if (num > 0) begin
                res.scaled_value = 17'((num << MMFN_QW) / span);
            end
            pending_scales.insert(pending_scales.size(), res);
        endfunction

        function void check_result(t_mmfn_res got);
            t_mmfn_res want;
            if (pending_scales.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: index %0d scaled %0d flat %0b",
                             got.result_index, got.scaled_value, got.flat_range);
                return;
            end
            want = pending_scales.pop_front();
            if (got.scaled_value !== want.scaled_value ||
                got.result_index !== want.result_index ||
                got.flat_range !== want.flat_range) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp idx %0d val %0d flat %0b, got idx %0d val %0d flat %0b",
                             want.result_index, want.scaled_value, want.flat_range,
                             got.result_index, got.scaled_value, got.flat_range);
            end
        endfunction
    endclass

    localparam int STALL_LIMIT = 2000;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  start       = 1'b0;
    logic                  busy;
    t_mmfn_req             i_req       = '0;
    logic                  o_done;
    t_mmfn_res             o_res;
    logic                  i_cfg_we    = 1'b0;
    logic [MMFN_CNT_W-1:0] i_cfg_wdata = '0;

    minmax_scoreboard sb = new();
    int gap_pct = 0;
    int quiet_cycles = 0;

    min_max_feature_normalizer_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_done      (o_done),
        .o_res       (o_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check_result(o_res);
    end

    // End the run when nothing has moved for too long.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || i_cfg_we || !i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[min_max_feature_normalizer_unit] ERROR");
            $finish;
        end
    end

    function automatic t_mmfn_req make_req(logic op, int unsigned idx, logic first,
                                           logic signed [31:0] val);
        t_mmfn_req r;
        r.req_type      = op;
        r.feature_index = idx[9:0];
        r.first_sample  = first;
        r.sample_value  = val;
        return r;
    endfunction

    // Mix full-range, extreme, small, near-bound and in-range values for one feature.
    function automatic logic signed [31:0] pick_value(int unsigned idx);
        longint          lo, hi, span;
        longint unsigned draw;
        int              kind;
        kind = sb.written[idx] ? $urandom_range(9) : $urandom_range(3);
        if (kind > 3) begin
            lo   = longint'(sb.min_store[idx]);
            hi   = longint'(sb.max_store[idx]);
            span = hi - lo;
        end
        draw = 64'($urandom());
        case (kind)
            0: return $urandom();
            1: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            2, 3: return 32'($urandom_range(32'h000F_FFFF) - 32'h0008_0000);
            4: return 32'(lo + $urandom_range(2) - 1);
            5: return 32'(hi + $urandom_range(2) - 1);
            default: return 32'(lo + longint'(draw % longint'(span + 1)));
        endcase
    endfunction

    task automatic push_request(input t_mmfn_req r);
        while ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        sb.note_request(r);
    endtask

    // Drain outstanding results, let a trailing observe finish, then reprogram.
    task automatic set_feature_count(input logic [MMFN_CNT_W-1:0] count);
        start <= 1'b0;
        while (sb.pending_scales.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= count;
        @(posedge i_clk);
        sb.feature_count = count;
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input logic [MMFN_CNT_W-1:0] count, input int pct, input int n);
        t_mmfn_req   r;
        int unsigned lim, idx, pool;
        set_feature_count(count);
        gap_pct = pct;
        lim = sb.in_use();
        pool = (lim < 12) ? lim : 12;
        for (int k = 0; k < n; k++) begin
            r.req_type     = 1'($urandom_range(1));
            r.first_sample = 1'($urandom_range(1));
            r.sample_value = $urandom();
            if (lim == 0 || (lim < MMFN_MAX_FEATURES && $urandom_range(99) < 8)) begin
                // out-of-use index: dropped, never touches the stores
                r.feature_index = 10'($urandom_range(MMFN_MAX_FEATURES - 1, lim));
            end else begin
                idx = ($urandom_range(99) < 70) ? $urandom_range(pool - 1)
                                                : $urandom_range(lim - 1);
                r.feature_index = idx[9:0];
                if (!sb.written[idx]) begin
                    r.req_type     = MMFN_REQ_OBSERVE;
                    r.first_sample = 1'b1;
                end else begin
                    r.req_type     = ($urandom_range(99) < 55) ? MMFN_REQ_NORMALIZE
                                                               : MMFN_REQ_OBSERVE;
                    r.first_sample = ($urandom_range(99) < 10);
                end
                r.sample_value = pick_value(idx);
            end
            push_request(r);
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // widest possible range, then its edges and midpoint
        push_request(make_req(MMFN_REQ_OBSERVE,   0, 1'b1, 32'sh8000_0000));
        push_request(make_req(MMFN_REQ_OBSERVE,   0, 1'b0, 32'sh7FFF_FFFF));
        push_request(make_req(MMFN_REQ_NORMALIZE, 0, 1'b0, 32'sh0000_0000));
        push_request(make_req(MMFN_REQ_NORMALIZE, 0, 1'b1, 32'sh8000_0000));
        push_request(make_req(MMFN_REQ_NORMALIZE, 0, 1'b0, 32'sh7FFF_FFFF));
        push_request(make_req(MMFN_REQ_NORMALIZE, 0, 1'b0, 32'sh7FFF_FFFE));
        // flat range on the last feature in use
        push_request(make_req(MMFN_REQ_OBSERVE,   783, 1'b1, 32'sh0005_0000));
        push_request(make_req(MMFN_REQ_NORMALIZE, 783, 1'b0, 32'sh0003_0000));
        // indices out of use are dropped
        push_request(make_req(MMFN_REQ_OBSERVE,   784, 1'b1, 32'sh0001_0000));
        push_request(make_req(MMFN_REQ_NORMALIZE, 784, 1'b0, 32'sh0001_0000));
        push_request(make_req(MMFN_REQ_NORMALIZE, 1023, 1'b1, 32'shFFFF_FFFF));
        // grow min and max, then below, above and inside the range
        push_request(make_req(MMFN_REQ_OBSERVE,   1, 1'b1, 32'sh0064_0000));
        push_request(make_req(MMFN_REQ_OBSERVE,   1, 1'b0, 32'sh00C8_0000));
        push_request(make_req(MMFN_REQ_OBSERVE,   1, 1'b0, 32'sh0032_0000));
        push_request(make_req(MMFN_REQ_OBSERVE,   1, 1'b0, 32'sh0096_0000));
        push_request(make_req(MMFN_REQ_NORMALIZE, 1, 1'b0, 32'sh000A_0000));
        push_request(make_req(MMFN_REQ_NORMALIZE, 1, 1'b0, 32'sh012C_0000));
        push_request(make_req(MMFN_REQ_NORMALIZE, 1, 1'b0, 32'sh0064_0000));
        push_request(make_req(MMFN_REQ_NORMALIZE, 1, 1'b0, 32'sh00C7_3039));
        // first_sample reloads both bounds
        push_request(make_req(MMFN_REQ_OBSERVE,   1, 1'b1, 32'shFFF9_0000));
        push_request(make_req(MMFN_REQ_NORMALIZE, 1, 1'b0, 32'shFFF9_0000));
        push_request(make_req(MMFN_REQ_NORMALIZE, 1, 1'b0, 32'sh0000_0000));
        // one-LSB range
        push_request(make_req(MMFN_REQ_OBSERVE,   2, 1'b1, 32'sh0000_0000));
        push_request(make_req(MMFN_REQ_OBSERVE,   2, 1'b0, 32'sh0000_0001));
        push_request(make_req(MMFN_REQ_NORMALIZE, 2, 1'b0, 32'sh0000_0001));

        run_phase(11'd784,  0,  60);
        run_phase(11'd1024, 67, 80);
        run_phase(11'd1,    0,  40);
        run_phase(11'd2047, 28, 80);
        run_phase(11'd0,    28, 20);
        run_phase(11'd37,   67, 80);
        run_phase(11'd1000, 0,  60);

        start <= 1'b0;
        while (sb.pending_scales.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_scales.size() == 0) begin
            $display("[min_max_feature_normalizer_unit] OK");
        end else begin
            $display("[min_max_feature_normalizer_unit] ERROR");
        end
        $finish;
    end

endmodule

### files.f
rtl/mmfn_pkg.sv
rtl/mmfn_store.sv
rtl/mmfn_div.sv
rtl/min_max_feature_normalizer_unit.sv
tb/tb_min_max_feature_normalizer_unit.sv
